FILE: rtl/cubic_spline_coef_stream_defines.svh
// Assertion macros for the cubic spline coefficient stream
`ifndef CUBIC_SPLINE_COEF_STREAM_DEFINES_SVH
`define CUBIC_SPLINE_COEF_STREAM_DEFINES_SVH
`ifndef SYNTH
`define CSC_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("csc assertion failed");
`define CSC_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("csc assertion failed");
`else
`define CSC_ASSERT_IMP(lbl, a, b)
`define CSC_ASSERT_NXT(lbl, a, b)
`endif
`endif

FILE: rtl/csc_pkg.sv
// Types, constants and functions shared by the spline coefficient stream
`timescale 1ns / 1ps
package csc_pkg;
  localparam int DATA_WIDTH   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int ANG_BITS     = 30;
  localparam int NORM_BITS    = 40;

  localparam int DIFF_W = DATA_WIDTH + 1;              // knot differences
  localparam int CX_W   = NORM_BITS + 4;               // cordic x/y, gain headroom
  localparam int Z_W    = ANG_BITS + 4;                // cordic angle
  localparam int K_W    = $clog2(CORDIC_STEPS);
  localparam int CF_W   = DATA_WIDTH + FRAC_BITS + 8;  // q, nn, mm
  localparam int NUM_W  = CF_W + 2 * FRAC_BITS;        // divider dividend
  localparam int DEN_W  = CX_W;                        // widest divisor: rotated x
  localparam int REM_W  = DEN_W + 1;
  localparam int DCNT_W = $clog2(NUM_W);

  localparam int IN_TDATA_W  = 2 * DATA_WIDTH;
  localparam int OUT_TDATA_W = 5 * DATA_WIDTH;

  localparam logic signed [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO_H = 2'd1;
  localparam logic [1:0] ST_SAT    = 2'd2;

  typedef enum logic {CM_VEC, CM_ROT} cmode_t;

  typedef enum logic [1:0] {CS_IDLE, CS_NORM, CS_ITER} cstate_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_VA_W, S_VB_W, S_ROT_W, S_TD_W, S_SEG, S_Q_W, S_NM,
    S_C3A, S_C3A_W, S_C3B_W, S_C2_W, S_EMIT
  } seq_state_t;

  // atan(2^-k), 2^ANG_BITS = 1 rad
  function automatic logic signed [Z_W-1:0] atan_step(input logic [K_W-1:0] k);
    logic signed [Z_W-1:0] v;
    v = '0;
    unique case (k)
      K_W'(0): v = Z_W'(843314857);
      K_W'(1): v = Z_W'(497837829);
      K_W'(2): v = Z_W'(263043837);
      K_W'(3): v = Z_W'(133525159);
      K_W'(4): v = Z_W'(67021687);
      K_W'(5): v = Z_W'(33543516);
      K_W'(6): v = Z_W'(16775851);
      K_W'(7): v = Z_W'(8388437);
      K_W'(8): v = Z_W'(4194283);
      K_W'(9): v = Z_W'(2097149);
      default: begin
        if (int'(k) <= ANG_BITS) v = Z_W'(1) << (ANG_BITS - int'(k));
      end
    endcase
    return v;
  endfunction
endpackage

FILE: rtl/csc_div.sv
// Shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module csc_div import csc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  sh;
  logic [REM_W:0]    diff;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh   = {rem_r[REM_W-2:0], q_r[NUM_W-1]};
    diff = {1'b0, sh} - {2'b00, den_r};
    if (busy_r) begin
      if (!diff[REM_W]) begin
        rem_nxt = diff[REM_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      if (cnt_r == DCNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

FILE: rtl/csc_cordic.sv
// Shared CORDIC unit: vectoring (with input normalization) and rotation
`timescale 1ns / 1ps
module csc_cordic import csc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  cmode_t                mode,
  input  logic [DIFF_W-1:0]     vec_x,
  input  logic [DIFF_W-1:0]     vec_y,
  input  logic signed [Z_W-1:0] angle,
  output logic                  done,
  output logic signed [CX_W-1:0] x_out,
  output logic signed [CX_W-1:0] y_out,
  output logic signed [Z_W-1:0] z_out
);
  localparam logic signed [CX_W-1:0] LIM = CX_W'(1) << NORM_BITS;

  cstate_t state_r, state_nxt;
  cmode_t  mode_r, mode_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic done_r, done_nxt;
  logic signed [CX_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic signed [CX_W-1:0] xs, ys;
  logic cw;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    k_nxt     = k_r;
    done_nxt  = 1'b0;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    xs = x_r >>> k_r;
    ys = y_r >>> k_r;
    // vectoring drives y to zero, rotation drives z to zero
    cw = (mode_r == CM_VEC) ? !y_r[CX_W-1] : z_r[Z_W-1];
    unique case (state_r)
      CS_IDLE: begin
        if (start) begin
          mode_nxt = mode;
          k_nxt    = '0;
          if (mode == CM_ROT) begin
            x_nxt     = LIM;
            y_nxt     = '0;
            z_nxt     = angle;
            state_nxt = CS_ITER;
          end else if (vec_x == '0 && vec_y == '0) begin
            x_nxt    = '0;
            y_nxt    = '0;
            z_nxt    = '0;
            done_nxt = 1'b1;
          end else begin
            x_nxt     = CX_W'(vec_x);
            y_nxt     = CX_W'(vec_y);
            z_nxt     = '0;
            state_nxt = CS_NORM;
          end
        end
      end
      CS_NORM: begin
        if (x_r < LIM && y_r < LIM) begin
          x_nxt = x_r <<< 1;
          y_nxt = y_r <<< 1;
        end else begin
          state_nxt = CS_ITER;
        end
      end
      CS_ITER: begin
        if (cw) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atan_step(k_r);
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atan_step(k_r);
        end
        if (k_r == K_W'(CORDIC_STEPS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = CS_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      done_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
endmodule

FILE: rtl/cubic_spline_coef_stream.sv
// Top level: knot stream in, cubic segment coefficients out, with sequencer
//
// channel | dir | beat contents
// in_     | in  | tdata: knot_x, knot_y; tlast: last_knot
// out_    | out | tdata: out_x, out_y, slope, half_second, sixth_third;
//         |     | tuser: status; tlast: final_result
//
// One knot at a time; in_tready is high only while the sequencer is idle.
// A knot between two others takes two CORDIC vectoring passes (normalize
// shifts plus CORDIC_STEPS iterations) and one rotation pass (CORDIC_STEPS
// iterations), then up to five divider passes on the shared divider; far
// fewer passes at an extremum or zero width.
// The last knot adds a closing segment of up to four more divider passes.
// Reset (synchronous, rst_n low) empties the knot pipeline.
// A stalled result waits in the output register; the next knot is still taken.
`timescale 1ns / 1ps
`include "cubic_spline_coef_stream_defines.svh"
module cubic_spline_coef_stream import csc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // knot_x, knot_y
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_x, out_y, slope, half_second, sixth_third
  output logic [1:0]             out_tuser,  // status
  output logic                   out_tlast
);
  seq_state_t state_r, state_nxt;
  logic [1:0] ks_r, ks_nxt;
  logic signed [DATA_WIDTH-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [DATA_WIDTH-1:0] prev_s_r, prev_s_nxt;
  logic signed [DATA_WIDTH-1:0] pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic signed [DATA_WIDTH-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic nlast_r, nlast_nxt;
  logic signed [Z_W-1:0] ang_a_r, ang_a_nxt, th_r, th_nxt;
  logic signed [DATA_WIDTH-1:0] s_r, s_nxt, c2_r, c2_nxt, c3_r, c3_nxt;
  logic signed [DATA_WIDTH-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [1:0] st_r, st_nxt;
  logic flag_r, flag_nxt, fin_r, fin_nxt, adv_r, adv_nxt, neg_r, neg_nxt;
  logic signed [DIFF_W-1:0] h_r, h_nxt;
  logic signed [CF_W-1:0] q_r, q_nxt, nn_r, nn_nxt, mm_r, mm_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] ox_r, oy_r, os_r, oc2_r, oc3_r;
  logic [1:0] ost_r;
  logic ofin_r;
  logic out_load;

  logic div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;
  logic cor_start, cor_done;
  cmode_t cor_mode;
  logic [DIFF_W-1:0] cor_vx, cor_vy;
  logic signed [Z_W-1:0] cor_ang, cor_z;
  logic signed [CX_W-1:0] cor_x, cor_y;

  logic in_acc;
  logic signed [DATA_WIDTH-1:0] in_x, in_y;
  logic signed [DIFF_W-1:0] dxa, dya, dxb, dyb, hd, dyq;
  logic signed [Z_W-1:0] ang_b;
  logic ext;
  logic [DATA_WIDTH:0] sat_t;

  function automatic logic [DIFF_W-1:0] abs_d(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  function automatic logic [CF_W-1:0] abs_c(input logic signed [CF_W-1:0] v);
    return v[CF_W-1] ? CF_W'(-v) : CF_W'(v);
  endfunction

  // {flag, value}: signed result from sign and magnitude, clamped
  function automatic logic [DATA_WIDTH:0] sat_mag(input logic neg,
                                                   input logic [NUM_W-1:0] m);
    logic [NUM_W-1:0] lim;
    logic [NUM_W-1:0] t;
    lim = NUM_W'(1) << (DATA_WIDTH - 1);
    t = NUM_W'(0) - m;
    if (neg) begin
      if (m > lim) return {1'b1, MIN_V};
      return {1'b0, t[DATA_WIDTH-1:0]};
    end
    if (m >= lim) return {1'b1, MAX_V};
    return {1'b0, m[DATA_WIDTH-1:0]};
  endfunction

  csc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  csc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .mode  (cor_mode),
    .vec_x (cor_vx),
    .vec_y (cor_vy),
    .angle (cor_ang),
    .done  (cor_done),
    .x_out (cor_x),
    .y_out (cor_y),
    .z_out (cor_z)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_x      = in_tdata[DATA_WIDTH-1:0];
  assign in_y      = in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

  assign dxa = DIFF_W'(pend_x_r) - DIFF_W'(prev_x_r);
  assign dya = DIFF_W'(pend_y_r) - DIFF_W'(prev_y_r);
  assign dxb = DIFF_W'(nx_r) - DIFF_W'(pend_x_r);
  assign dyb = DIFF_W'(ny_r) - DIFF_W'(pend_y_r);
  assign hd  = DIFF_W'(prev_x_r) - DIFF_W'(pend_x_r);
  assign dyq = DIFF_W'(prev_y_r) - DIFF_W'(pend_y_r);
  assign ext = (pend_y_r >= prev_y_r && pend_y_r >= ny_r) ||
               (pend_y_r <= prev_y_r && pend_y_r <= ny_r);
  assign ang_b = neg_r ? -cor_z : cor_z;

  always_comb begin
    state_nxt  = state_r;
    ks_nxt     = ks_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    prev_s_nxt = prev_s_r;
    pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;
    nx_nxt     = nx_r;
    ny_nxt     = ny_r;
    nlast_nxt  = nlast_r;
    ang_a_nxt  = ang_a_r;
    th_nxt     = th_r;
    s_nxt      = s_r;
    c2_nxt     = c2_r;
    c3_nxt     = c3_r;
    res_x_nxt  = res_x_r;
    res_y_nxt  = res_y_r;
    st_nxt     = st_r;
    flag_nxt   = flag_r;
    fin_nxt    = fin_r;
    adv_nxt    = adv_r;
    neg_nxt    = neg_r;
    h_nxt      = h_r;
    q_nxt      = q_r;
    nn_nxt     = nn_r;
    mm_nxt     = mm_r;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    cor_start  = 1'b0;
    cor_mode   = CM_VEC;
    cor_vx     = '0;
    cor_vy     = '0;
    cor_ang    = '0;
    out_load   = 1'b0;
    sat_t      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          nx_nxt    = in_x;
          ny_nxt    = in_y;
          nlast_nxt = in_tlast;
          if (ks_r == 2'd1) begin
            // second knot: the first one goes out with zero coefficients
            res_x_nxt = pend_x_r;
            res_y_nxt = pend_y_r;
            s_nxt     = '0;
            c2_nxt    = '0;
            c3_nxt    = '0;
            st_nxt    = ST_OK;
            fin_nxt   = 1'b0;
            adv_nxt   = 1'b1;
            state_nxt = S_EMIT;
          end else if (ks_r == 2'd2) begin
            state_nxt = S_CHK;
          end else if (in_tlast) begin
            // single-knot set
            res_x_nxt = in_x;
            res_y_nxt = in_y;
            s_nxt     = '0;
            c2_nxt    = '0;
            c3_nxt    = '0;
            st_nxt    = ST_OK;
            fin_nxt   = 1'b1;
            adv_nxt   = 1'b0;
            ks_nxt    = 2'd0;
            state_nxt = S_EMIT;
          end else begin
            pend_x_nxt = in_x;
            pend_y_nxt = in_y;
            ks_nxt     = 2'd1;
          end
        end
      end
      S_CHK: begin
        fin_nxt = 1'b0;
        adv_nxt = 1'b1;
        if (ext) begin
          s_nxt     = '0;
          flag_nxt  = 1'b0;
          state_nxt = S_SEG;
        end else begin
          cor_start = 1'b1;
          cor_mode  = CM_VEC;
          cor_vx    = abs_d(dxa);
          cor_vy    = abs_d(dya);
          neg_nxt   = dxa[DIFF_W-1] ^ dya[DIFF_W-1];
          state_nxt = S_VA_W;
        end
      end
      S_VA_W: begin
        if (cor_done) begin
          ang_a_nxt = ang_b;
          cor_start = 1'b1;
          cor_mode  = CM_VEC;
          cor_vx    = abs_d(dxb);
          cor_vy    = abs_d(dyb);
          neg_nxt   = dxb[DIFF_W-1] ^ dyb[DIFF_W-1];
          state_nxt = S_VB_W;
        end
      end
      S_VB_W: begin
        if (cor_done) begin
          th_nxt    = (ang_a_r + ang_b) >>> 1;
          cor_start = 1'b1;
          cor_mode  = CM_ROT;
          cor_ang   = (ang_a_r + ang_b) >>> 1;
          state_nxt = S_ROT_W;
        end
      end
      S_ROT_W: begin
        if (cor_done) begin
          if (cor_x[CX_W-1] || cor_x == '0) begin
            s_nxt     = th_r[Z_W-1] ? MIN_V : MAX_V;
            flag_nxt  = 1'b1;
            state_nxt = S_SEG;
          end else begin
            div_start = 1'b1;
            div_num   = NUM_W'(cor_y[CX_W-1] ? CX_W'(-cor_y) : CX_W'(cor_y)) << FRAC_BITS;
            div_den   = DEN_W'(cor_x);
            neg_nxt   = cor_y[CX_W-1];
            state_nxt = S_TD_W;
          end
        end
      end
      S_TD_W: begin
        if (div_done) begin
          sat_t     = sat_mag(neg_r, div_quot);
          s_nxt     = sat_t[DATA_WIDTH-1:0];
          flag_nxt  = sat_t[DATA_WIDTH];
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        res_x_nxt = pend_x_r;
        res_y_nxt = pend_y_r;
        h_nxt     = hd;
        if (hd == '0) begin
          s_nxt     = '0;
          c2_nxt    = '0;
          c3_nxt    = '0;
          st_nxt    = ST_ZERO_H;
          state_nxt = S_EMIT;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'(abs_d(dyq)) << FRAC_BITS;
          div_den   = DEN_W'(abs_d(hd));
          neg_nxt   = dyq[DIFF_W-1] ^ hd[DIFF_W-1];
          state_nxt = S_Q_W;
        end
      end
      S_Q_W: begin
        if (div_done) begin
          q_nxt = neg_r ? -$signed(div_quot[CF_W-1:0]) : $signed(div_quot[CF_W-1:0]);
          state_nxt = S_NM;
        end
      end
      S_NM: begin
        nn_nxt = CF_W'(prev_s_r) + CF_W'(s_r) - (q_r <<< 1);
        mm_nxt = (q_r <<< 1) + q_r - (CF_W'(s_r) <<< 1) - CF_W'(prev_s_r);
        state_nxt = S_C3A;
      end
      S_C3A: begin
        div_start = 1'b1;
        div_num   = NUM_W'(abs_c(nn_r)) << (2 * FRAC_BITS);
        div_den   = DEN_W'(abs_d(h_r));
        state_nxt = S_C3A_W;
      end
      S_C3A_W: begin
        // n/h^2 taken as (n/h)/h, exact under truncation
        if (div_done) begin
          div_start = 1'b1;
          div_num   = div_quot;
          div_den   = DEN_W'(abs_d(h_r));
          state_nxt = S_C3B_W;
        end
      end
      S_C3B_W: begin
        if (div_done) begin
          sat_t     = sat_mag(nn_r[CF_W-1], div_quot);
          c3_nxt    = sat_t[DATA_WIDTH-1:0];
          flag_nxt  = flag_r | sat_t[DATA_WIDTH];
          div_start = 1'b1;
          div_num   = NUM_W'(abs_c(mm_r)) << FRAC_BITS;
          div_den   = DEN_W'(abs_d(h_r));
          state_nxt = S_C2_W;
        end
      end
      S_C2_W: begin
        if (div_done) begin
          sat_t     = sat_mag(mm_r[CF_W-1] ^ h_r[DIFF_W-1], div_quot);
          c2_nxt    = sat_t[DATA_WIDTH-1:0];
          st_nxt    = (flag_r | sat_t[DATA_WIDTH]) ? ST_SAT : ST_OK;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          if (adv_r) begin
            prev_x_nxt = pend_x_r;
            prev_y_nxt = pend_y_r;
            prev_s_nxt = (st_r == ST_ZERO_H) ? '0 : s_r;
            pend_x_nxt = nx_r;
            pend_y_nxt = ny_r;
            if (nlast_r) begin
              // closing segment for the last knot, slope zero
              s_nxt     = '0;
              flag_nxt  = 1'b0;
              fin_nxt   = 1'b1;
              adv_nxt   = 1'b0;
              state_nxt = S_SEG;
            end else begin
              ks_nxt    = 2'd2;
              state_nxt = S_IDLE;
            end
          end else begin
            ks_nxt    = 2'd0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ks_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ks_r        <= ks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_x_r <= prev_x_nxt;
    prev_y_r <= prev_y_nxt;
    prev_s_r <= prev_s_nxt;
    pend_x_r <= pend_x_nxt;
    pend_y_r <= pend_y_nxt;
    nx_r     <= nx_nxt;
    ny_r     <= ny_nxt;
    nlast_r  <= nlast_nxt;
    ang_a_r  <= ang_a_nxt;
    th_r     <= th_nxt;
    s_r      <= s_nxt;
    c2_r     <= c2_nxt;
    c3_r     <= c3_nxt;
    res_x_r  <= res_x_nxt;
    res_y_r  <= res_y_nxt;
    st_r     <= st_nxt;
    flag_r   <= flag_nxt;
    fin_r    <= fin_nxt;
    adv_r    <= adv_nxt;
    neg_r    <= neg_nxt;
    h_r      <= h_nxt;
    q_r      <= q_nxt;
    nn_r     <= nn_nxt;
    mm_r     <= mm_nxt;
    if (out_load) begin
      ox_r   <= res_x_r;
      oy_r   <= res_y_r;
      os_r   <= s_r;
      oc2_r  <= c2_r;
      oc3_r  <= c3_r;
      ost_r  <= st_r;
      ofin_r <= fin_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {oc3_r, oc2_r, os_r, oy_r, ox_r};
  assign out_tuser  = ost_r;
  assign out_tlast  = ofin_r;

  `CSC_ASSERT_IMP(a_div_done_wait, div_done, (state_r == S_TD_W || state_r == S_Q_W || state_r == S_C3A_W || state_r == S_C3B_W || state_r == S_C2_W))
  `CSC_ASSERT_IMP(a_cor_done_wait, cor_done, (state_r == S_VA_W || state_r == S_VB_W || state_r == S_ROT_W))
  `CSC_ASSERT_IMP(a_load_slot_free, out_load, (!out_valid_r || out_tready))
  `CSC_ASSERT_NXT(a_inner_knot_check, (in_acc && ks_r == 2'd2), (state_r == S_CHK))
endmodule
